[design/tcw_pkg.sv]
// tcw_pkg: shared constants, codes and types of the text console writer
// no dependencies; used by every other file of the block but tcw_ram
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int CROW_W     = 5;
  localparam int CCOL_W     = 7;
  localparam int COLOR_W    = 4;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_NEWLINE,
    OP_PUT,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [CHAR_W-1:0]     ch;
    logic [RROW_W-1:0]     rrow;
    logic [RCOL_W-1:0]     rcol;
    logic                  in_range;
  } op_t;

  // head of the queue as the back end sees it
  typedef struct packed {
    logic valid;
    op_t  op;
  } qhead_t;

  typedef struct packed {
    logic [CROW_W-1:0] crow;
    logic [CCOL_W-1:0] ccol;
    logic              scroll;
    logic [CHAR_W-1:0] cchar;
    logic [ATTR_W-1:0] cattr;
  } result_t;

endpackage

`default_nettype wire

[design/tcw_if.sv]
// tcw_if: valid/ready channel interfaces for commands, results and configuration
// depends on tcw_pkg for field widths
`default_nettype none

interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CMD_W-1:0]    command;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::RROW_W-1:0]   read_row;
  logic [tcw_pkg::RCOL_W-1:0]   read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink   (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CROW_W-1:0]   cursor_row_out;
  logic [tcw_pkg::CCOL_W-1:0]   cursor_col_out;
  logic                         did_scroll;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

  modport source (output valid, cursor_row_out, cursor_col_out, did_scroll, cell_char,
                  cell_attr, input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, did_scroll, cell_char,
                  cell_attr, output ready);
endinterface

interface tcw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::CFG_IDX_W-1:0]    index;
  logic [tcw_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/tcw_ram.sv]
// tcw_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/tcw_front.sv]
// tcw_front: accepts command items, classifies them and holds them in a short queue
// depends on tcw_pkg and tcw_in_if
`default_nettype none

module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  tcw_in_if.sink           in_ch,
  output tcw_pkg::qhead_t  head,
  input  wire              pop
);

  localparam int PTR_W = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::op_t      q_mem [tcw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  tcw_pkg::op_t      op_in;
  logic              push;
  logic              do_pop;

  // classification of the incoming item
  always_comb begin
    op_in.ch       = in_ch.char_code;
    op_in.rrow     = in_ch.read_row;
    op_in.rcol     = in_ch.read_col;
    op_in.in_range = (32'(in_ch.read_row) < 32'(ROWS)) &&
                     (32'(in_ch.read_col) < 32'(COLUMNS));
    case (in_ch.command)
      tcw_pkg::CMD_PUT: begin
        op_in.kind = (in_ch.char_code == tcw_pkg::NEWLINE_CODE) ?
                     tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
      end
      tcw_pkg::CMD_CLEAR: begin
        op_in.kind = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::CMD_READ: begin
        op_in.kind = tcw_pkg::OP_READ;
      end
      default: begin
        op_in.kind = tcw_pkg::OP_NOP;
      end
    endcase
  end

  assign in_ch.ready = (count_r != CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count_r != '0);

  assign head.valid  = (count_r != '0);
  assign head.op     = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= op_in;
    end
  end

endmodule

`default_nettype wire

[design/tcw_back.sv]
// tcw_back: executes queued commands on the cursor and the screen store, drives results
// depends on tcw_pkg, tcw_out_if and tcw_ram
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire tcw_pkg::qhead_t          head,
  output logic                          pop,
  input  wire [tcw_pkg::ATTR_W-1:0]     attr,
  tcw_out_if.source                     out_ch
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int CIDX_W = $clog2(COLUMNS);
  localparam int CCUR_W = $clog2(COLUMNS + 1);
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RADDR = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_WADDR = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;

  logic [2:0]                   state_r, state_nxt;
  tcw_pkg::op_t                 op_r, op_nxt;
  logic [ROW_W-1:0]             crow_r, crow_nxt;
  logic [CCUR_W-1:0]            ccol_r, ccol_nxt;
  logic [ROW_W-1:0]             top_r, top_nxt;
  logic [ROWS-1:0]              blank_r, blank_nxt;
  logic [tcw_pkg::CELL_W-1:0]   fill_r [ROWS];
  logic [tcw_pkg::CELL_W-1:0]   fill_nxt [ROWS];
  logic                         scroll_r, scroll_nxt;
  logic [CIDX_W-1:0]            fcol_r, fcol_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tcw_pkg::result_t             out_r;

  logic                         out_free;
  logic                         at_bottom;
  logic [ROW_W-1:0]             top_inc;
  logic [ROW_W-1:0]             lrow;
  logic [ROW_W:0]               row_sum;
  logic [ROW_W-1:0]             phys;
  logic [CIDX_W-1:0]            acol;
  logic [ADDR_W-1:0]            addr;
  logic [tcw_pkg::CELL_W-1:0]   blank_cell;
  logic                         nl_go;
  logic                         emit;
  logic                         e_scroll;
  logic [tcw_pkg::CHAR_W-1:0]   e_char;
  logic [tcw_pkg::ATTR_W-1:0]   e_attr;
  logic                         mem_we;
  logic                         mem_re;
  logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
  logic [tcw_pkg::CELL_W-1:0]   mem_rdata;
  tcw_pkg::result_t             res;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign at_bottom  = (crow_r == ROW_W'(ROWS - 1));
  assign top_inc    = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
  assign blank_cell = {attr, tcw_pkg::SPACE_CODE};

  // logical row to physical row through the rotating top pointer
  assign lrow    = (state_r == S_RADDR) ? ROW_W'(op_r.rrow) : crow_r;
  assign row_sum = {1'b0, lrow} + {1'b0, top_r};
  assign phys    = (row_sum >= (ROW_W + 1)'(ROWS)) ?
                   ROW_W'(row_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(row_sum);

  always_comb begin
    case (state_r)
      S_RADDR: acol = CIDX_W'(op_r.rcol);
      S_FILL:  acol = fcol_r;
      default: acol = CIDX_W'(ccol_r);
    endcase
  end

  assign addr = ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(acol);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    crow_nxt   = crow_r;
    ccol_nxt   = ccol_r;
    top_nxt    = top_r;
    blank_nxt  = blank_r;
    fill_nxt   = fill_r;
    scroll_nxt = scroll_r;
    fcol_nxt   = fcol_r;
    pop        = 1'b0;
    nl_go      = 1'b0;
    emit       = 1'b0;
    e_scroll   = 1'b0;
    e_char     = '0;
    e_attr     = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = '0;

    case (state_r)
      S_IDLE: begin
        if (head.valid && out_free) begin
          pop       = 1'b1;
          op_nxt    = head.op;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r.kind)
          tcw_pkg::OP_CLEAR: begin
            for (int r = 0; r < ROWS; r++) begin
              blank_nxt[r] = 1'b1;
              fill_nxt[r]  = blank_cell;
            end
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          tcw_pkg::OP_NEWLINE: begin
            nl_go     = 1'b1;
            e_scroll  = at_bottom;
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          tcw_pkg::OP_PUT: begin
            // a full line wraps before the write
            if (ccol_r == CCUR_W'(COLUMNS)) begin
              nl_go      = 1'b1;
              scroll_nxt = at_bottom;
            end else begin
              scroll_nxt = 1'b0;
            end
            state_nxt = S_WADDR;
          end
          tcw_pkg::OP_READ: begin
            if (op_r.in_range) begin
              state_nxt = S_RADDR;
            end else begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RADDR: begin
        // a blank row is not in the store yet
        if (blank_r[phys]) begin
          emit      = 1'b1;
          e_char    = fill_r[phys][tcw_pkg::CHAR_W-1:0];
          e_attr    = fill_r[phys][tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_RDATA;
        end
      end
      S_RDATA: begin
        emit      = 1'b1;
        e_char    = mem_rdata[tcw_pkg::CHAR_W-1:0];
        e_attr    = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_nxt = S_IDLE;
      end
      S_WADDR: begin
        if (blank_r[phys]) begin
          fcol_nxt  = '0;
          state_nxt = S_FILL;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {attr, op_r.ch};
          ccol_nxt  = ccol_r + CCUR_W'(1);
          e_scroll  = scroll_r;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        // materialize the blank row before the first write into it
        mem_we    = 1'b1;
        mem_wdata = fill_r[phys];
        if (fcol_r == CIDX_W'(COLUMNS - 1)) begin
          blank_nxt[phys] = 1'b0;
          state_nxt       = S_WADDR;
        end else begin
          fcol_nxt = fcol_r + CIDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (nl_go) begin
      ccol_nxt = '0;
      if (!at_bottom) begin
        crow_nxt = crow_r + ROW_W'(1);
      end else begin
        // old top row becomes the new bottom row, blank in the current color
        top_nxt          = top_inc;
        blank_nxt[top_r] = 1'b1;
        fill_nxt[top_r]  = blank_cell;
      end
    end
  end

  always_comb begin
    res.crow   = tcw_pkg::CROW_W'(crow_nxt);
    res.ccol   = tcw_pkg::CCOL_W'(ccol_nxt);
    res.scroll = e_scroll;
    res.cchar  = e_char;
    res.cattr  = e_attr;
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      crow_r      <= '0;
      ccol_r      <= '0;
      top_r       <= '0;
      blank_r     <= '1;
      scroll_r    <= 1'b0;
      fcol_r      <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        fill_r[r] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      top_r       <= top_nxt;
      blank_r     <= blank_nxt;
      scroll_r    <= scroll_nxt;
      fcol_r      <= fcol_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (emit) begin
      out_r <= res;
    end
  end

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_row_out = out_r.crow;
  assign out_ch.cursor_col_out = out_r.ccol;
  assign out_ch.did_scroll     = out_r.scroll;
  assign out_ch.cell_char      = out_r.cchar;
  assign out_ch.cell_attr      = out_r.cattr;

endmodule

`default_nettype wire

[design/text_console_writer.sv]
// text_console_writer: text screen with cursor, scrolling, clear and cell read
// depends on tcw_pkg, tcw_if, tcw_front, tcw_back (which holds tcw_ram)
// results are registered: clear, newline, no-op and off-screen reads emit in S_EXEC,
// a read of a blank row in S_RADDR, of a written cell in S_RDATA, a put into a written
// row in S_WADDR; a put into a blank row first fills it through the single store write
// port in S_FILL; the back end runs one item at a time, taking the next only in S_IDLE
// reset: synchronous active-low; cursor to 0,0, colors to 15/0, every row reads as zero
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch,
  tcw_cfg_if.sink    cfg_ch
);

  logic [tcw_pkg::COLOR_W-1:0] fg_r;
  logic [tcw_pkg::COLOR_W-1:0] bg_r;
  tcw_pkg::qhead_t             head;
  logic                        pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::FG_RESET;
      bg_r <= tcw_pkg::BG_RESET;
    end else if (cfg_ch.valid) begin
      // writes past the last register are dropped
      if (cfg_ch.index == tcw_pkg::REG_FG) begin
        fg_r <= cfg_ch.data[tcw_pkg::COLOR_W-1:0];
      end
      if (cfg_ch.index == tcw_pkg::REG_BG) begin
        bg_r <= cfg_ch.data[tcw_pkg::COLOR_W-1:0];
      end
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .attr   ({bg_r, fg_r}),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[design/tcw_checker.sv]
// tcw_checker: assertions on the result port of text_console_writer, bound to the top level
// depends on tcw_pkg
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [tcw_pkg::CROW_W-1:0]     cursor_row_out,
  input wire [tcw_pkg::CCOL_W-1:0]     cursor_col_out,
  input wire                           did_scroll,
  input wire [tcw_pkg::CHAR_W-1:0]     cell_char,
  input wire [tcw_pkg::ATTR_W-1:0]     cell_attr
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_row_out) &&
    $stable(cursor_col_out) && $stable(did_scroll) && $stable(cell_char) &&
    $stable(cell_attr))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(cursor_row_out) < 32'(ROWS)) &&
                  (32'(cursor_col_out) <= 32'(COLUMNS)))
    else $error("cursor out of range");

  // a scroll leaves the cursor at the start of the bottom row, or just past a wrapped put
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && did_scroll |-> (cursor_row_out == tcw_pkg::CROW_W'(ROWS - 1)) &&
                                (cursor_col_out <= tcw_pkg::CCOL_W'(1)) &&
                                (cell_char == '0) && (cell_attr == '0))
    else $error("scroll item with wrong cursor or cell data");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cursor_row_out (out_ch.cursor_row_out),
  .cursor_col_out (out_ch.cursor_col_out),
  .did_scroll     (out_ch.did_scroll),
  .cell_char      (out_ch.cell_char),
  .cell_attr      (out_ch.cell_attr)
);

`default_nettype wire
